FILE: sv/dsq_pkg.sv
// Shared types, constants and the arctangent table for the direction sector quantiser.
// No dependencies; every other file in the block refers to it by scoped names.

package dsq_pkg;

   localparam int VEL_BITS     = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int MAX_FRAMES   = 256;
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 64;
   localparam int PRE_SHIFT    = 61 - VEL_BITS;
   localparam int ANG_W        = 32;
   localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
   localparam int FRAME_W      = 8;
   localparam int COUNT_W      = 9;
   localparam int PRODUCT_W    = ANGLE_BITS + COUNT_W + 1;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

   localparam logic [ANG_W-1:0] ANG_POS_Y = 32'h0000_0000;
   localparam logic [ANG_W-1:0] ANG_POS_X = 32'h4000_0000;
   localparam logic [ANG_W-1:0] ANG_NEG_Y = 32'h8000_0000;
   localparam logic [ANG_W-1:0] ANG_NEG_X = 32'hC000_0000;

   typedef struct packed {
      logic signed [VEL_BITS-1:0] vel_x;
      logic signed [VEL_BITS-1:0] vel_y;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               updated;
      logic               held;
   } rsp_type;

   typedef struct packed {
      logic                       valid;
      logic                       is_zero;
      logic                       is_axis;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic [ANG_W-1:0]           ang;
   } cordic_stage_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle;
      logic                  is_zero;
   } angle_item_type;

   function automatic logic [ANG_W-1:0] atan_turns(input logic [STEP_IDX_W-1:0] idx);
      logic [ANG_W-1:0] t;
      case (idx)
         5'd0:    t = 32'h2000_0000;
         5'd1:    t = 32'h12E4_051E;
         5'd2:    t = 32'h09FB_385B;
         5'd3:    t = 32'h0511_11D4;
         5'd4:    t = 32'h028B_0D43;
         5'd5:    t = 32'h0145_D7E1;
         5'd6:    t = 32'h00A2_F61E;
         5'd7:    t = 32'h0051_7C55;
         5'd8:    t = 32'h0028_BE53;
         5'd9:    t = 32'h0014_5F2F;
         5'd10:   t = 32'h000A_2F98;
         5'd11:   t = 32'h0005_17CC;
         5'd12:   t = 32'h0002_8BE6;
         5'd13:   t = 32'h0001_45F3;
         5'd14:   t = 32'h0000_A2F9;
         5'd15:   t = 32'h0000_517C;
         5'd16:   t = 32'h0000_28BE;
         5'd17:   t = 32'h0000_145F;
         5'd18:   t = 32'h0000_0A2F;
         5'd19:   t = 32'h0000_0517;
         5'd20:   t = 32'h0000_028B;
         5'd21:   t = 32'h0000_0145;
         5'd22:   t = 32'h0000_00A2;
         5'd23:   t = 32'h0000_0051;
         5'd24:   t = 32'h0000_0028;
         5'd25:   t = 32'h0000_0014;
         5'd26:   t = 32'h0000_000A;
         5'd27:   t = 32'h0000_0005;
         5'd28:   t = 32'h0000_0002;
         5'd29:   t = 32'h0000_0001;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: sv/dsq_front.sv
// Front end: pipelined CORDIC that turns a velocity beat into a fraction-of-turn angle.
// Depends on dsq_pkg; one iteration per stage after the input stage, the whole pipe stalls together.

module dsq_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dsq_pkg::req_type         req_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dsq_pkg::angle_item_type  out_item
);

   localparam int LAST = dsq_pkg::CORDIC_STEPS;

   dsq_pkg::cordic_stage_type stg_ff [0:LAST];
   dsq_pkg::cordic_stage_type stg_in [0:LAST];
   logic                      adv;

   assign adv       = !stg_ff[LAST].valid || out_ready;
   assign req_ready = adv;
   assign out_valid = stg_ff[LAST].valid;
   assign out_item.angle   = stg_ff[LAST].ang[dsq_pkg::ANG_W-1 -: dsq_pkg::ANGLE_BITS];
   assign out_item.is_zero = stg_ff[LAST].is_zero;

   always_comb begin
      logic signed [dsq_pkg::CORDIC_W-1:0] x_ext;
      logic signed [dsq_pkg::CORDIC_W-1:0] y_ext;
      x_ext = dsq_pkg::CORDIC_W'(req_data.vel_x) <<< dsq_pkg::PRE_SHIFT;
      y_ext = dsq_pkg::CORDIC_W'(req_data.vel_y) <<< dsq_pkg::PRE_SHIFT;
      stg_in[0].valid   = req_valid;
      stg_in[0].is_zero = (req_data.vel_x == '0) && (req_data.vel_y == '0);
      stg_in[0].is_axis = (req_data.vel_x == '0) || (req_data.vel_y == '0);
      if (req_data.vel_y < 0) begin
         stg_in[0].x = -x_ext;
         stg_in[0].y = -y_ext;
      end else begin
         stg_in[0].x = x_ext;
         stg_in[0].y = y_ext;
      end
      priority if (req_data.vel_x == '0) begin
         stg_in[0].ang = (req_data.vel_y < 0) ? dsq_pkg::ANG_NEG_Y : dsq_pkg::ANG_POS_Y;
      end else if (req_data.vel_y == '0) begin
         stg_in[0].ang = (req_data.vel_x < 0) ? dsq_pkg::ANG_NEG_X : dsq_pkg::ANG_POS_X;
      end else begin
         stg_in[0].ang = (req_data.vel_y < 0) ? dsq_pkg::ANG_NEG_Y : dsq_pkg::ANG_POS_Y;
      end
   end

   for (genvar g = 0; g < LAST; g++) begin : g_iter
      logic signed [dsq_pkg::CORDIC_W-1:0] xs;
      logic signed [dsq_pkg::CORDIC_W-1:0] ys;
      logic signed [dsq_pkg::CORDIC_W-1:0] dx;
      logic signed [dsq_pkg::CORDIC_W-1:0] dy;
      logic [dsq_pkg::ANG_W-1:0]           step;

      assign xs   = stg_ff[g].x;
      assign ys   = stg_ff[g].y;
      assign dx   = xs >>> g;
      assign dy   = ys >>> g;
      assign step = dsq_pkg::atan_turns(dsq_pkg::STEP_IDX_W'(g));

      always_comb begin
         stg_in[g+1] = stg_ff[g];
         if (!xs[dsq_pkg::CORDIC_W-1]) begin
            stg_in[g+1].y = ys + dx;
            stg_in[g+1].x = xs - dy;
            if (!stg_ff[g].is_axis) begin
               stg_in[g+1].ang = stg_ff[g].ang + step;
            end
         end else begin
            stg_in[g+1].y = ys - dx;
            stg_in[g+1].x = xs + dy;
            if (!stg_ff[g].is_axis) begin
               stg_in[g+1].ang = stg_ff[g].ang - step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= LAST; k++) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

endmodule

FILE: sv/dsq_queue.sv
// Short register queue that decouples the angle front end from the sector back end.
// Depends on dsq_pkg for the item type and the depth.

module dsq_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  dsq_pkg::angle_item_type  push_item,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output dsq_pkg::angle_item_type  pop_item
);

   dsq_pkg::angle_item_type           entry_ff [dsq_pkg::QUEUE_DEPTH];
   logic [dsq_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dsq_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dsq_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              push, pop;

   assign push_ready = count_ff != dsq_pkg::QUEUE_CNT_W'(dsq_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/dsq_back.sv
// Back end: maps an angle to a sector, keeps the current frame and registers the response.
// Depends on dsq_pkg; one multiply and compare per beat ahead of the output register.

module dsq_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [dsq_pkg::COUNT_W-1:0]    frame_count,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  dsq_pkg::angle_item_type        in_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dsq_pkg::rsp_type               rsp_data
);

   logic                               rsp_valid_ff;
   dsq_pkg::rsp_type                   rsp_data_ff, rsp_data_in;
   logic [dsq_pkg::FRAME_W-1:0]        cur_frame_ff;
   logic [dsq_pkg::COUNT_W-1:0]        n_eff;
   logic [dsq_pkg::PRODUCT_W-1:0]      product;
   logic [dsq_pkg::COUNT_W:0]          q;
   logic [dsq_pkg::COUNT_W:0]          q_plus;
   logic [dsq_pkg::ANGLE_BITS-1:0]     r;
   logic [dsq_pkg::COUNT_W-1:0]        half;
   logic [dsq_pkg::FRAME_W-1:0]        sector;
   logic                               take;

   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign take      = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      n_eff   = (frame_count > dsq_pkg::COUNT_W'(dsq_pkg::MAX_FRAMES))
              ? dsq_pkg::COUNT_W'(dsq_pkg::MAX_FRAMES) : frame_count;
      product = dsq_pkg::PRODUCT_W'(in_item.angle) * dsq_pkg::PRODUCT_W'({n_eff, 1'b0});
      q       = product[dsq_pkg::PRODUCT_W-1:dsq_pkg::ANGLE_BITS];
      r       = product[dsq_pkg::ANGLE_BITS-1:0];
      q_plus  = q + 1'b1;
      half    = q_plus[dsq_pkg::COUNT_W:1];
      sector  = (half == n_eff) ? '0 : half[dsq_pkg::FRAME_W-1:0];
      rsp_data_in.updated = 1'b1;
      rsp_data_in.held    = 1'b0;
      priority if (n_eff == '0) begin
         rsp_data_in.frame   = cur_frame_ff;
         rsp_data_in.updated = 1'b0;
      end else if (in_item.is_zero) begin
         rsp_data_in.frame = '0;
      end else if ((r == '0) && q[0]) begin
         rsp_data_in.frame = cur_frame_ff;
         rsp_data_in.held  = 1'b1;
      end else begin
         rsp_data_in.frame = sector;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_frame_ff <= '0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
         cur_frame_ff <= rsp_data_in.frame;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: sv/direction_sector_quantizer.sv
// Top level of the direction sector quantiser: CORDIC front end, queue, sector back end.
// Depends on dsq_pkg, dsq_front, dsq_queue and dsq_back.
//
//   port group   dir   handshake          payload
//   req_         in    req_valid/ready    dsq_pkg::req_type (vel_x, vel_y)
//   rsp_         out   rsp_valid/ready    dsq_pkg::rsp_type (frame, updated, held)
//   csr_         in    csr_write          csr_data, frame count (9 bits)
//
// One beat per cycle is accepted and delivered while nothing stalls.
// A request beat passes through 31 CORDIC pipeline stages, the four-entry queue
// and the output register before its response is valid.
// Synchronous reset clears control, the current frame, and sets the frame count to 8.
// A stalled response fills the queue first; the CORDIC pipe stalls as a whole only
// when the queue is full and its last stage holds a beat.

module direction_sector_quantizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dsq_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dsq_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [dsq_pkg::COUNT_W-1:0]    csr_data
);

   logic [dsq_pkg::COUNT_W-1:0]  frame_count_ff;
   logic                         fe_valid, fe_ready;
   dsq_pkg::angle_item_type      fe_item;
   logic                         be_valid, be_ready;
   dsq_pkg::angle_item_type      be_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= dsq_pkg::COUNT_RESET;
      end else if (csr_write) begin
         frame_count_ff <= csr_data;
      end
   end

   dsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_item  (fe_item)
   );

   dsq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_item  (fe_item),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_item   (be_item)
   );

   dsq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_count (frame_count_ff),
      .in_valid    (be_valid),
      .in_ready    (be_ready),
      .in_item     (be_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: sv/dsq_checker.sv
// Port-level checks for the direction sector quantiser, bound to the top level.
// Depends on dsq_pkg; tracks the frame count and the last delivered frame.

module dsq_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  dsq_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  dsq_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [dsq_pkg::COUNT_W-1:0]    csr_data
);

   logic [dsq_pkg::COUNT_W-1:0]  count_ff;
   logic [dsq_pkg::FRAME_W-1:0]  last_frame_ff;
   logic [dsq_pkg::COUNT_W-1:0]  n_eff;

   assign n_eff = (count_ff > dsq_pkg::COUNT_W'(dsq_pkg::MAX_FRAMES))
                ? dsq_pkg::COUNT_W'(dsq_pkg::MAX_FRAMES) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= dsq_pkg::COUNT_RESET;
         last_frame_ff <= '0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            last_frame_ff <= rsp_data.frame;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_keep_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.held || !rsp_data.updated) |-> rsp_data.frame == last_frame_ff)
      else $error("kept frame differs from last delivered frame");

   a_held_updated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.held |-> rsp_data.updated)
      else $error("held set without update");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.updated && !rsp_data.held
         |-> dsq_pkg::COUNT_W'(rsp_data.frame) < n_eff)
      else $error("selected frame beyond frame count");

endmodule

bind direction_sector_quantizer dsq_checker u_dsq_chk (.*);

FILE: tb/tb_direction_sector_quantizer.sv
// Self-checking testbench for direction_sector_quantizer: directed axis, edge and count
// cases, then random vectors over a sweep of frame counts with random stalls on both sides.
// Depends on dsq_pkg and the direction_sector_quantizer top level.

module tb_direction_sector_quantizer;

   localparam int RUN_LIMIT   = 600000;
   localparam int SETTLE_WAIT = 40;
   localparam int MAX_GAP     = 12;
   localparam int PHASE_ITEMS = 135;

   localparam logic [31:0] TURN_POS_Y = 32'h0000_0000;
   localparam logic [31:0] TURN_POS_X = 32'h4000_0000;
   localparam logic [31:0] TURN_NEG_Y = 32'h8000_0000;
   localparam logic [31:0] TURN_NEG_X = 32'hC000_0000;

   localparam logic [31:0] ATAN_STEP [30] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
      32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
      32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
      32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
      32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
      32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001
   };

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   dsq_pkg::req_type            req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   dsq_pkg::rsp_type            rsp_data;
   logic                        csr_write;
   logic [dsq_pkg::COUNT_W-1:0] csr_data;

   logic [dsq_pkg::COUNT_W-1:0] model_count;
   logic [dsq_pkg::FRAME_W-1:0] model_frame;
   dsq_pkg::rsp_type            expected_frames[$];
   int                          error_count = 0;
   int                          cycle_count = 0;
   bit                          quiet_mode  = 1'b0;

   direction_sector_quantizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAIL direction_sector_quantizer");
         $finish;
      end
   end

   function automatic logic [31:0] vector_turns(logic signed [15:0] vx, logic signed [15:0] vy);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [31:0]        ang;
      if (vx == 0)
         return (vy < 0) ? TURN_NEG_Y : TURN_POS_Y;
      if (vy == 0)
         return (vx < 0) ? TURN_NEG_X : TURN_POS_X;
      x   = vx;
      y   = vy;
      x   = x <<< dsq_pkg::PRE_SHIFT;
      y   = y <<< dsq_pkg::PRE_SHIFT;
      ang = TURN_POS_Y;
      if (y < 0) begin
         x   = -x;
         y   = -y;
         ang = TURN_NEG_Y;
      end
      for (int i = 0; i < 30; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (x >= 0) begin
            y   = y + dx;
            x   = x - dy;
            ang = ang + ATAN_STEP[i];
         end else begin
            y   = y - dx;
            x   = x + dy;
            ang = ang - ATAN_STEP[i];
         end
      end
      return ang;
   endfunction

   function automatic dsq_pkg::rsp_type predict_frame(dsq_pkg::req_type v);
      dsq_pkg::rsp_type res;
      int unsigned      n;
      int unsigned      a;
      int unsigned      s;
      int unsigned      q;
      int unsigned      r;
      logic [31:0]      turns;
      n   = (model_count > dsq_pkg::MAX_FRAMES) ? dsq_pkg::MAX_FRAMES : 32'(model_count);
      res = '0;
      if (n == 0) begin
         res.frame = model_frame;
         return res;
      end
      res.updated = 1'b1;
      if (v.vel_x == 0 && v.vel_y == 0) begin
         model_frame = '0;
      end else begin
         turns = vector_turns(v.vel_x, v.vel_y);
         a     = 32'(turns[31:16]);
         s     = a * 2 * n;
         q     = s >> 16;
         r     = s & 32'h0000_FFFF;
         if (r == 0 && q[0])
            res.held = 1'b1;
         else
            model_frame = dsq_pkg::FRAME_W'(((q + 1) / 2) % n);
      end
      res.frame = model_frame;
      return res;
   endfunction

   function automatic dsq_pkg::req_type vec(int x, int y);
      dsq_pkg::req_type v;
      v.vel_x = 16'(x);
      v.vel_y = 16'(y);
      return v;
   endfunction

   function automatic logic [15:0] random_component();
      logic [15:0] c;
      case ($urandom_range(0, 5))
         0: c = 16'($signed($urandom_range(0, 8)) - 4);
         1: begin
            case ($urandom_range(0, 5))
               0: c = 16'h8000;
               1: c = 16'h8001;
               2: c = 16'hFFFF;
               3: c = 16'h0000;
               4: c = 16'h0001;
               default: c = 16'h7FFF;
            endcase
         end
         default: c = 16'($urandom);
      endcase
      return c;
   endfunction

   function automatic int draw_gap();
      if (quiet_mode || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // Called at a rising edge; returns at the edge that accepted the beat.
   task automatic send_vector(dsq_pkg::req_type v);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      expected_frames.push_back(predict_frame(v));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain_pipe();
      csr_write <= 1'b1;
      csr_data  <= dsq_pkg::COUNT_W'(value);
      @(posedge clock);
      csr_write   <= 1'b0;
      model_count = dsq_pkg::COUNT_W'(value);
   endtask

   initial begin
      int gap;
      rsp_ready <= 1'b0;
      do
         @(posedge clock);
      while (reset !== 1'b0);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      dsq_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("unexpected beat, frame", rsp_data.frame, -1);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_data.frame !== want.frame)
               report_mismatch("frame", rsp_data.frame, want.frame);
            if (rsp_data.updated !== want.updated)
               report_mismatch("updated", rsp_data.updated, want.updated);
            if (rsp_data.held !== want.held)
               report_mismatch("held", rsp_data.held, want.held);
         end
      end
   end

   task automatic test_axes_and_extremes();
      send_vector(vec(0, 0));
      send_vector(vec(100, 0));
      send_vector(vec(-1, 0));
      send_vector(vec(0, 32767));
      send_vector(vec(0, -32768));
      send_vector(vec(32767, 32767));
      send_vector(vec(-32768, -32768));
      send_vector(vec(-32768, 32767));
      send_vector(vec(32767, -32768));
      send_vector(vec(-1, -1));
   endtask

   task automatic test_edge_hold();
      write_count(1);
      send_vector(vec(5, 0));
      send_vector(vec(0, -7));
      write_count(2);
      send_vector(vec(0, -3));
      send_vector(vec(9, 0));
      send_vector(vec(-9, 0));
      send_vector(vec(0, 1));
      send_vector(vec(-32768, 0));
   endtask

   task automatic test_disabled_count();
      write_count(2);
      send_vector(vec(0, -1));
      write_count(0);
      send_vector(vec(123, -456));
      send_vector(vec(0, 0));
      send_vector(vec(-32768, 32767));
   endtask

   task automatic test_saturated_count();
      write_count(511);
      send_vector(vec(3, 7));
      send_vector(vec(-20000, 15000));
      write_count(257);
      send_vector(vec(1, -1));
      send_vector(vec(0, 0));
   endtask

   task automatic test_random_sweep();
      int counts[10] = '{8, 3, 256, 0, 255, 2, 100, 511, 1, 7};
      for (int p = 0; p < 10; p++) begin
         write_count(counts[p]);
         quiet_mode = (p % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 0 && k == PHASE_ITEMS / 2)
               drain_pipe();
            send_vector(vec($signed(random_component()), $signed(random_component())));
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_write   <= 1'b0;
      csr_data    <= '0;
      reset       <= 1'b1;
      model_count = dsq_pkg::COUNT_W'(8);
      model_frame = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_axes_and_extremes();
      test_edge_hold();
      test_disabled_count();
      test_saturated_count();
      test_random_sweep();
      drain_pipe();
      if (error_count == 0)
         $display("PASS direction_sector_quantizer");
      else
         $display("FAIL direction_sector_quantizer");
      $finish;
   end

endmodule
